// File: hw/rtl/ordered_key_set_top_defines.svh
// assertion macros shared by the ordered key set rtl
`ifndef ORDERED_KEY_SET_TOP_DEFINES_SVH
`define ORDERED_KEY_SET_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OKS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define OKS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant that holds at every edge out of reset
`define OKS_ASSERT_ALW(lbl, expr, msg) \
    `OKS_ASSERT_IMP(lbl, 1'b1, expr, msg)

`endif

// File: hw/rtl/oks_pkg.sv
// shared constants, operation codes and interface structs of the ordered key set
`default_nettype none
package oks_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_W    = 32;
    localparam int OP_W     = 3;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int GROUP    = 16;
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
    localparam int GRP_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_EXISTS = 3'd2,
        OP_NEXT   = 3'd3,
        OP_PREV   = 3'd4
    } op_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic             sample;
        logic             ins;
        logic             ers;
    } cell_cmd_t;

    // compare flags handed between neighbouring cells
    typedef struct packed {
        logic lt;
        logic gt;
    } cell_flags_t;

    // collected outcome of the group scan
    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] val;
        logic             last;
    } scan_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/oks_cell.sv
// one cell of the sorted row: holds a key, compares it and shifts with its neighbours
`default_nettype none
module oks_cell (
    input  wire                          clk,
    input  wire oks_pkg::cell_cmd_t      cmd,
    input  wire                          valid,
    input  wire [oks_pkg::KEY_W-1:0]     left_key,
    input  wire [oks_pkg::KEY_W-1:0]     right_key,
    input  wire oks_pkg::cell_flags_t    left_flags,
    input  wire oks_pkg::cell_flags_t    right_flags,
    output oks_pkg::cell_flags_t         flags,
    output logic [oks_pkg::KEY_W-1:0]    key_out,
    output logic                         hit,
    output logic [oks_pkg::KEY_W-1:0]    val
);

    logic [oks_pkg::KEY_W-1:0] key_reg;
    logic [oks_pkg::KEY_W-1:0] key_next;
    logic                      hit_reg;
    logic [oks_pkg::KEY_W-1:0] val_reg;
    logic                      lt;
    logic                      gt;
    logic                      eq;
    logic                      hit_c;
    logic                      take_val;

    // local compares against the broadcast key
    always_comb
    begin
        lt = valid && ($signed(key_reg) < $signed(cmd.key));
        gt = valid && ($signed(key_reg) > $signed(cmd.key));
        eq = valid && (key_reg == cmd.key);
    end

    // selection: exact match, first greater or last smaller
    always_comb
    begin
        hit_c    = 1'b0;
        take_val = 1'b0;
        unique case (cmd.op)
            oks_pkg::OP_INSERT,
            oks_pkg::OP_ERASE,
            oks_pkg::OP_EXISTS:
            begin
                hit_c = eq;
            end
            oks_pkg::OP_NEXT:
            begin
                hit_c    = gt && !left_flags.gt;
                take_val = 1'b1;
            end
            oks_pkg::OP_PREV:
            begin
                hit_c    = lt && !right_flags.lt;
                take_val = 1'b1;
            end
            default:
            begin
                hit_c = 1'b0;
            end
        endcase
    end

    // insert opens a gap at the boundary, erase closes it
    always_comb
    begin
        key_next = key_reg;
        priority if (cmd.ins && !lt)
        begin
            key_next = left_flags.lt ? cmd.key : left_key;
        end
        else if (cmd.ers && !lt)
        begin
            key_next = right_key;
        end
    end

    // key storage and sampled selection
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (cmd.sample)
        begin
            hit_reg <= hit_c;
            val_reg <= (hit_c && take_val) ? key_reg : '0;
        end
    end

    assign flags.lt = lt;
    assign flags.gt = gt;
    assign key_out  = key_reg;
    assign hit      = hit_reg;
    assign val      = val_reg;

endmodule
`default_nettype wire

// File: hw/rtl/oks_scan.sv
// gathers the single selected cell, one group of cells per cycle while run is high
`default_nettype none
module oks_scan (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       clear,
    input  wire                       run,
    input  wire                       hit [oks_pkg::CAPACITY],
    input  wire [oks_pkg::KEY_W-1:0]  val [oks_pkg::CAPACITY],
    output oks_pkg::scan_res_t        res
);

    logic [oks_pkg::GRP_W-1:0] cnt_reg;
    logic [oks_pkg::GRP_W-1:0] cnt_next;
    logic                      hit_reg;
    logic [oks_pkg::KEY_W-1:0] val_reg;
    logic                      grp_hit [oks_pkg::NGROUPS];
    logic [oks_pkg::KEY_W-1:0] grp_val [oks_pkg::NGROUPS];
    logic                      last;

    // per-group or of the sampled cell outputs
    always_comb
    begin
        for (int g = 0; g < oks_pkg::NGROUPS; g++)
        begin
            grp_hit[g] = 1'b0;
            grp_val[g] = '0;
            for (int j = 0; j < oks_pkg::GROUP; j++)
            begin
                if (g * oks_pkg::GROUP + j < oks_pkg::CAPACITY)
                begin
                    grp_hit[g] = grp_hit[g] | hit[g * oks_pkg::GROUP + j];
                    grp_val[g] = grp_val[g] | val[g * oks_pkg::GROUP + j];
                end
            end
        end
    end

    // group counter
    always_comb
    begin
        last     = run && (cnt_reg == oks_pkg::GRP_W'(oks_pkg::NGROUPS - 1));
        cnt_next = cnt_reg;
        priority if (clear || last)
        begin
            cnt_next = '0;
        end
        else if (run)
        begin
            cnt_next = cnt_reg + oks_pkg::GRP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // accumulate the chosen group
    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            hit_reg <= 1'b0;
            val_reg <= '0;
        end
        else if (run)
        begin
            hit_reg <= hit_reg | grp_hit[cnt_reg];
            val_reg <= val_reg | grp_val[cnt_reg];
        end
    end

    assign res.hit  = hit_reg;
    assign res.val  = val_reg;
    assign res.last = last;

endmodule
`default_nettype wire

// File: hw/rtl/ordered_key_set_top.sv
// top level of the ordered key set: command sequencer, cell row and group scan
//
// Ordered set of distinct signed 32-bit keys held in ascending order in a row
// of CAPACITY cells (256). A command transfer happens at a rising edge with
// start high and busy low; operation and key are sampled there. Operations:
// insert, erase, exists, next greater, previous smaller.
// The result is shown for one cycle with done high: found, result_key and
// overflow. The receiver cannot stall; each result must be taken as shown.
// Steps: every cell compares against the held key and samples its selection
// (ST_SAMPLE), the scan gathers 16 cells per cycle over the NGROUPS =
// CAPACITY/16 groups (ST_SCAN), and the row shifts while the result is
// registered (ST_COMMIT). busy is low again in the done cycle, so a new
// command may be transferred at the edge that ends it; no new command is
// taken while one is in flight.
// Reset empties the store at once (key count to zero); no clearing pass runs,
// and busy is already low while reset is held.
`default_nettype none
`include "ordered_key_set_top_defines.svh"
module ordered_key_set_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [oks_pkg::OP_W-1:0]      operation,
    input  wire signed [oks_pkg::KEY_W-1:0] key,
    output logic                         done,
    output logic                         found,
    output logic signed [oks_pkg::KEY_W-1:0] result_key,
    output logic                         overflow
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t                      state_reg;
    logic [oks_pkg::OP_W-1:0]    op_reg;
    logic [oks_pkg::KEY_W-1:0]   key_reg;
    logic [oks_pkg::COUNT_W-1:0] count_reg;
    logic                        done_reg;
    logic                        found_reg;
    logic [oks_pkg::KEY_W-1:0]   result_key_reg;
    logic                        overflow_reg;

    oks_pkg::cell_cmd_t          cmd;
    oks_pkg::scan_res_t          scan_res;
    oks_pkg::op_t                op;
    logic                        full;
    logic                        present;
    logic                        is_query;

    logic                        valid     [oks_pkg::CAPACITY];
    oks_pkg::cell_flags_t        flags     [oks_pkg::CAPACITY];
    logic [oks_pkg::KEY_W-1:0]   cell_key  [oks_pkg::CAPACITY];
    logic                        cell_hit  [oks_pkg::CAPACITY];
    logic [oks_pkg::KEY_W-1:0]   cell_val  [oks_pkg::CAPACITY];

    // decode of the held command
    always_comb
    begin
        op       = oks_pkg::op_t'(op_reg);
        full     = (count_reg == oks_pkg::COUNT_W'(oks_pkg::CAPACITY));
        present  = scan_res.hit;
        is_query = (op == oks_pkg::OP_EXISTS) || (op == oks_pkg::OP_NEXT)
                   || (op == oks_pkg::OP_PREV);
    end

    // broadcast to the row
    always_comb
    begin
        cmd.op     = op;
        cmd.key    = key_reg;
        cmd.sample = (state_reg == ST_SAMPLE);
        cmd.ins    = (state_reg == ST_COMMIT) && (op == oks_pkg::OP_INSERT)
                     && !present && !full;
        cmd.ers    = (state_reg == ST_COMMIT) && (op == oks_pkg::OP_ERASE) && present;
    end

    // row of cells, each linked to its neighbours
    genvar i;
    generate
        for (i = 0; i < oks_pkg::CAPACITY; i++)
        begin : g_cell
            oks_pkg::cell_flags_t left_flags;
            oks_pkg::cell_flags_t right_flags;
            logic [oks_pkg::KEY_W-1:0] left_key;
            logic [oks_pkg::KEY_W-1:0] right_key;

            assign valid[i] = (oks_pkg::COUNT_W'(i) < count_reg);

            // beyond the left end sits a key below everything
            if (i == 0)
            begin : g_first
                assign left_flags.lt = 1'b1;
                assign left_flags.gt = 1'b0;
                assign left_key      = '0;
            end
            else
            begin : g_inner_l
                assign left_flags = flags[i-1];
                assign left_key   = cell_key[i-1];
            end

            // beyond the right end nothing is stored
            if (i == oks_pkg::CAPACITY - 1)
            begin : g_last
                assign right_flags.lt = 1'b0;
                assign right_flags.gt = 1'b0;
                assign right_key      = '0;
            end
            else
            begin : g_inner_r
                assign right_flags = flags[i+1];
                assign right_key   = cell_key[i+1];
            end

            oks_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .valid       (valid[i]),
                .left_key    (left_key),
                .right_key   (right_key),
                .left_flags  (left_flags),
                .right_flags (right_flags),
                .flags       (flags[i]),
                .key_out     (cell_key[i]),
                .hit         (cell_hit[i]),
                .val         (cell_val[i])
            );
        end
    endgenerate

    // gather of the selected cell
    oks_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (state_reg == ST_SAMPLE),
        .run   (state_reg == ST_SCAN),
        .hit   (cell_hit),
        .val   (cell_val),
        .res   (scan_res)
    );

    // sequencer with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= '0;
            key_reg        <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            result_key_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_COMMIT);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= operation;
                        key_reg   <= key;
                        state_reg <= ST_SAMPLE;
                    end
                end
                ST_SAMPLE:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (scan_res.last)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (cmd.ins)
                    begin
                        count_reg <= count_reg + oks_pkg::COUNT_W'(1);
                    end
                    else if (cmd.ers)
                    begin
                        count_reg <= count_reg - oks_pkg::COUNT_W'(1);
                    end
                    found_reg      <= is_query && scan_res.hit;
                    result_key_reg <= scan_res.val;
                    overflow_reg   <= (op == oks_pkg::OP_INSERT) && !present && full;
                    state_reg      <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign result_key = result_key_reg;
    assign overflow   = overflow_reg;

    // checks on the sequencer and the store
    `OKS_ASSERT_ALW(a_count_bound, count_reg <= oks_pkg::COUNT_W'(oks_pkg::CAPACITY), "key count above capacity")
    `OKS_ASSERT_NXT(a_start_busy, start && !busy, busy && !done, "command transfer did not raise busy")
    `OKS_ASSERT_IMP(a_count_change, !$stable(count_reg), done, "key count changed outside a commit")
    `OKS_ASSERT_IMP(a_ovf_clean, done && overflow, !found && (result_key == '0), "overflow with found or key set")

endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench for the ordered key set: queued commands, shadow sorted store and result checks
module testbench;
    import oks_pkg::*;

    localparam int LATENCY    = NGROUPS + 3;
    localparam int IDLE_LIMIT = 1000;
    localparam int ROUNDS     = 2;
    localparam int MIX_LEN    = 220;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
    } command_t;

    typedef struct packed {
        logic                    found;
        logic signed [KEY_W-1:0] neighbour;
        logic                    overflow;
    } answer_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    logic [OP_W-1:0]         operation = '0;
    logic signed [KEY_W-1:0] key       = '0;
    logic                    busy;
    logic                    done;
    logic                    found;
    logic signed [KEY_W-1:0] result_key;
    logic                    overflow;

    command_t                pending_cmds[$];
    answer_t                 answer_q[$];
    logic signed [KEY_W-1:0] key_pool[$];

    // shadow copy of the sorted store
    logic signed [KEY_W-1:0] shadow_keys[CAPACITY];
    int                      shadow_count = 0;

    int       mismatches  = 0;
    int       idle_cycles = 0;
    int       burst_left  = 1;
    int       gap_left    = 0;
    command_t next_cmd;
    answer_t  seen;

    ordered_key_set_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .key        (key),
        .done       (done),
        .found      (found),
        .result_key (result_key),
        .overflow   (overflow)
    );

    // clock and reset
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // first stored position at or above k, or strictly above k
    function automatic int first_pos(input logic signed [KEY_W-1:0] k, input bit strict);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (strict ? (shadow_keys[i] > k) : (shadow_keys[i] >= k))
                return i;
        end
        return shadow_count;
    endfunction

    // apply one command to the shadow store and work out its answer
    function automatic answer_t apply_cmd(input command_t c);
        answer_t a;
        int      pos;
        a = '0;
        case (c.op)
            OP_INSERT:
            begin
                pos = first_pos(c.key, 1'b0);
                if (!(pos < shadow_count && shadow_keys[pos] == c.key))
                begin
                    if (shadow_count >= CAPACITY)
                        a.overflow = 1'b1;
                    else
                    begin
                        for (int i = shadow_count; i > pos; i--)
                            shadow_keys[i] = shadow_keys[i-1];
                        shadow_keys[pos] = c.key;
                        shadow_count++;
                    end
                end
            end
            OP_ERASE:
            begin
                pos = first_pos(c.key, 1'b0);
                if (pos < shadow_count && shadow_keys[pos] == c.key)
                begin
                    for (int i = pos; i < shadow_count - 1; i++)
                        shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                end
            end
            OP_EXISTS:
            begin
                pos = first_pos(c.key, 1'b0);
                a.found = (pos < shadow_count && shadow_keys[pos] == c.key);
            end
            OP_NEXT:
            begin
                pos = first_pos(c.key, 1'b1);
                if (pos < shadow_count)
                begin
                    a.found     = 1'b1;
                    a.neighbour = shadow_keys[pos];
                end
            end
            OP_PREV:
            begin
                pos = first_pos(c.key, 1'b0);
                if (pos > 0)
                begin
                    a.found     = 1'b1;
                    a.neighbour = shadow_keys[pos-1];
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic void add_cmd(input op_t op, input logic signed [KEY_W-1:0] k);
        command_t c;
        c.op  = op;
        c.key = k;
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // mostly pool keys and their neighbours, some extremes, some anything
    function automatic logic signed [KEY_W-1:0] pick_key();
        int                      sel;
        logic signed [KEY_W-1:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 70 && key_pool.size() > 0)
        begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            case ($urandom_range(0, 3))
                0:       k = k + 1;
                1:       k = k - 1;
                default: ;
            endcase
        end
        else if (sel < 85)
        begin
            case ($urandom_range(0, 5))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                3:       k = -1;
                4:       k = KEY_MIN + 1;
                default: k = KEY_MAX - 1;
            endcase
        end
        else
            k = $urandom;
        return k;
    endfunction

    task automatic note_mismatch(input string what, input answer_t exp, input answer_t act);
        if (mismatches < 10)
            $display("mismatch (%s) at %0t: exp found=%0b key=%0d ovf=%0b, got %0b %0d %0b",
                     what, $realtime, exp.found, exp.neighbour, exp.overflow,
                     act.found, act.neighbour, act.overflow);
        mismatches++;
    endtask

    // stimulus and end of run
    initial
    begin
        int                      n;
        int                      step;
        int                      j;
        logic signed [KEY_W-1:0] base;
        logic signed [KEY_W-1:0] tmp;

        // directed: empty store, extremes, duplicates, missing neighbours
        add_cmd(OP_NEXT, KEY_MIN);   add_cmd(OP_PREV, KEY_MAX);
        add_cmd(OP_EXISTS, 0);       add_cmd(OP_ERASE, 0);
        add_cmd(OP_INSERT, KEY_MIN); add_cmd(OP_INSERT, KEY_MAX);
        add_cmd(OP_INSERT, 0);       add_cmd(OP_INSERT, -1);
        add_cmd(OP_INSERT, 1);       add_cmd(OP_INSERT, 0);
        add_cmd(OP_EXISTS, KEY_MIN); add_cmd(OP_EXISTS, KEY_MAX);
        add_cmd(OP_NEXT, KEY_MIN);   add_cmd(OP_PREV, KEY_MIN);
        add_cmd(OP_NEXT, KEY_MAX);   add_cmd(OP_PREV, KEY_MAX);
        add_cmd(OP_NEXT, -1);        add_cmd(OP_PREV, 0);
        add_cmd(OP_ERASE, 0);        add_cmd(OP_ERASE, 0);
        add_cmd(OP_EXISTS, 0);       add_cmd(OP_NEXT, -1);
        add_cmd(OP_ERASE, KEY_MIN);  add_cmd(OP_ERASE, KEY_MAX);
        add_cmd(OP_PREV, KEY_MAX);

        for (int r = 0; r < ROUNDS; r++)
        begin
            // fill past capacity with distinct keys in shuffled order
            n    = $urandom_range(CAPACITY + 1, CAPACITY + 16);
            step = $urandom_range(1, 1000);
            if (r == 0)
                base = $urandom;
            else
                base = KEY_MAX - (n * step) / 2;   // progression wraps past the top
            key_pool.delete();
            for (int i = 0; i < n; i++)
            begin
                tmp = base + i * step;
                key_pool.insert(key_pool.size(), tmp);
            end
            for (int i = n - 1; i > 0; i--)
            begin
                j           = $urandom_range(0, i);
                tmp         = key_pool[i];
                key_pool[i] = key_pool[j];
                key_pool[j] = tmp;
            end
            foreach (key_pool[i])
            begin
                add_cmd(OP_INSERT, key_pool[i]);
                if ($urandom_range(0, 9) == 0)
                    add_cmd(op_t'($urandom_range(OP_INSERT, OP_PREV)), pick_key());
            end

            // any operation on a full store
            repeat (MIX_LEN)
                add_cmd(op_t'($urandom_range(OP_INSERT, OP_PREV)), pick_key());

            // drain most of the pool with lookups in between
            foreach (key_pool[i])
            begin
                if ($urandom_range(0, 4) != 0)
                    add_cmd(OP_ERASE, key_pool[i]);
                if ($urandom_range(0, 4) == 0)
                    add_cmd(op_t'($urandom_range(OP_EXISTS, OP_PREV)), pick_key());
            end
        end

        // wait for every transfer and every answer
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || answer_q.size() != 0);
        repeat (2 * LATENCY) @(negedge clk);
        mismatches += answer_q.size();
        if (mismatches == 0)
            $display("** ordered_key_set_top: PASSED **");
        else
            $display("** ordered_key_set_top: FAILED **");
        $finish;
    end

    // driver: bursts of commands with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            operation <= '0;
            key       <= '0;
        end
        else
        begin
            // command transfer at this edge: predict its answer
            if (start && !busy)
            begin
                next_cmd.op  = op_t'(operation);
                next_cmd.key = key;
                answer_q.insert(answer_q.size(), apply_cmd(next_cmd));
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    start     <= 1'b1;
                    operation <= next_cmd.op;
                    key       <= next_cmd.key;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: check each result and watch for a stalled block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                seen.found     = found;
                seen.neighbour = result_key;
                seen.overflow  = overflow;
                if (answer_q.size() == 0)
                    note_mismatch("nothing outstanding", '0, seen);
                else if (seen !== answer_q[0])
                    note_mismatch("wrong field", answer_q.pop_front(), seen);
                else
                    void'(answer_q.pop_front());
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** ordered_key_set_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
